[hw/rtl/nws_pkg.sv]
// Shared constants, codes and types for the weighted-sum sigmoid neuron.
package nws_pkg;

	// Default parameter values
	localparam int MAX_INPUTS_DEF = 32;
	localparam int DATA_WIDTH_DEF = 16;

	// Arithmetic widths: Q.24 accumulator, Q.12 result
	localparam int ACC_W     = 40;
	localparam int FRAC_BITS = 12;
	localparam int Q_W       = ACC_W - FRAC_BITS;
	localparam int RES_W     = 32;
	localparam int SIG_W     = 13;

	// Element counter
	localparam int CNT_W   = 6;
	localparam int CNT_MAX = 63;

	// Request codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_ELEM  = 1'b1;

	// Configuration register map
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_SIGMOID = 1'd1;
	localparam logic [CNT_W-1:0]     INPUT_COUNT_RST = 6'd4;
	localparam logic                 USE_SIGMOID_RST = 1'b1;

	// PLAN sigmoid breakpoints (on |x| in Q.12) and offsets
	localparam logic [Q_W-1:0]   SIG_SAT_TH  = Q_W'(20480);
	localparam logic [Q_W-1:0]   SIG_MID_TH  = Q_W'(9728);
	localparam logic [Q_W-1:0]   SIG_LOW_TH  = Q_W'(4096);
	localparam logic [SIG_W-1:0] SIG_ONE     = 13'd4096;
	localparam logic [SIG_W-1:0] SIG_OFS_HI  = 13'd3456;
	localparam logic [SIG_W-1:0] SIG_OFS_MID = 13'd2560;
	localparam logic [SIG_W-1:0] SIG_OFS_LO  = 13'd2048;

	// Controls handed to the result stage
	typedef struct packed {
		logic err;
		logic use_sig;
	} nws_post_ctl_t;

endpackage

[hw/rtl/neuron_weighted_sum_sigmoid.sv]
// Top level of the fixed-point neuron: weight store, MAC pipeline, output buffer.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_ready  | cmd, index, value (Q4.12), last
//  out      | out_valid / out_ready| result (Q.12), count_error
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle is taken while the skid entry is empty, weight writes
// and elements alike; the multiply-accumulate pipeline (weight read, multiply,
// accumulate, result) needs no stall between elements. After the last element,
// its result passes the stage 1, 2 and 3 and output registers to out_valid.
// Reset clears the accumulator, element count and configuration (count 4,
// sigmoid on); the weight store is not cleared and must be written first.
// A two-entry output buffer (result register plus skid) decouples the sides;
// in_ready drops only while the skid entry holds a result.
module neuron_weighted_sum_sigmoid #(
	parameter int MAX_INPUTS = nws_pkg::MAX_INPUTS_DEF,
	parameter int DATA_WIDTH = nws_pkg::DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input requests
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  cmd,
	input  logic [nws_pkg::CNT_W-1:0]             index,
	input  logic signed [DATA_WIDTH-1:0]          value,
	input  logic                                  last,
	// results
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [nws_pkg::RES_W-1:0]      result,
	output logic                                  count_error,
	// configuration
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [nws_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [nws_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import nws_pkg::*;

	localparam int AW = $clog2(MAX_INPUTS + 1);

	// configuration registers
	logic [CNT_W-1:0] input_count_q;
	logic             use_sigmoid_q;

	// weight store: entries 0..MAX_INPUTS; weights sit below index input_count
	// (clipped to MAX_INPUTS) and the bias sits at that index
	logic signed [DATA_WIDTH-1:0] wmem [MAX_INPUTS+1];

	// front end
	logic             en;
	logic             acc_wr;
	logic             acc_elem;
	logic             idx_ok;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic [CNT_W-1:0] n_eff;
	logic             mac_en;
	logic [AW-1:0]    wt_addr;
	logic [AW-1:0]    bias_addr;

	// stage 1: registered memory reads
	logic                         vld_s1, last_s1, err_s1, mac_s1;
	logic signed [DATA_WIDTH-1:0] val_s1, wt_s1, bias_s1;
	logic signed [2*DATA_WIDTH-1:0] prod_full;

	// stage 2: product and scaled bias
	logic                    vld_s2, last_s2, err_s2;
	logic signed [ACC_W-1:0] prod_s2, bias_s2;

	// accumulator and stage 3: final sum
	logic signed [ACC_W-1:0] acc_q;
	logic                    res_vld_s3, err_s3;
	logic signed [ACC_W-1:0] sum_s3;

	// result stage and output buffer
	nws_post_ctl_t           post_ctl;
	logic signed [RES_W-1:0] post_res;
	logic                    out_valid_q, skid_vld_q;
	logic signed [RES_W-1:0] res_q, skid_res_q;
	logic                    err_q, skid_err_q;

	//--------------------------------------------------------------------------
	// configuration port, always ready
	//--------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_count_q <= INPUT_COUNT_RST;
			use_sigmoid_q <= USE_SIGMOID_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_INPUT_COUNT: input_count_q <= CNT_W'(cfg_data);
				CFG_USE_SIGMOID: use_sigmoid_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// request decode and element counting
	//--------------------------------------------------------------------------
	// whole pipeline holds only while the skid entry is occupied
	assign en       = !skid_vld_q;
	assign in_ready = en;
	assign acc_wr   = in_valid && in_ready && (cmd == CMD_WRITE);
	assign acc_elem = in_valid && in_ready && (cmd == CMD_ELEM);
	assign idx_ok   = int'(index) <= MAX_INPUTS;

	// count above the store size is clipped to it
	assign n_eff   = (int'(input_count_q) > MAX_INPUTS) ? CNT_W'(MAX_INPUTS) : input_count_q;
	assign mac_en  = cnt_q < n_eff;
	assign cnt_nxt = (cnt_q != CNT_W'(CNT_MAX)) ? CNT_W'(cnt_q + 1'b1) : cnt_q;

	assign wt_addr   = mac_en ? AW'(cnt_q) : '0;
	assign bias_addr = AW'(n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc_elem) begin
			cnt_q <= last ? '0 : cnt_nxt;
		end
	end

	// weight store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (acc_wr && idx_ok)
			wmem[AW'(index)] <= value;
	end

	always_ff @(posedge clk) begin
		if (acc_elem) begin
			wt_s1   <= wmem[wt_addr];
			bias_s1 <= wmem[bias_addr];
			val_s1  <= value;
		end
	end

	//--------------------------------------------------------------------------
	// pipeline control
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			last_s1    <= 1'b0;
			err_s1     <= 1'b0;
			mac_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			last_s2    <= 1'b0;
			err_s2     <= 1'b0;
			res_vld_s3 <= 1'b0;
			err_s3     <= 1'b0;
			acc_q      <= '0;
		end else if (en) begin
			vld_s1  <= acc_elem;
			last_s1 <= acc_elem && last;
			err_s1  <= cnt_nxt != n_eff;
			mac_s1  <= mac_en;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			err_s2  <= err_s1;
			res_vld_s3 <= vld_s2 && last_s2;
			err_s3     <= err_s2;
			if (vld_s2)
				acc_q <= last_s2 ? '0 : ACC_W'(acc_q + prod_s2);
		end
	end

	// Q4.12 x Q4.12 -> Q.24, sign-extended to the accumulator width
	assign prod_full = val_s1 * wt_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= mac_s1 ? ACC_W'(prod_full) : '0;
			bias_s2 <= ACC_W'(bias_s1) <<< FRAC_BITS;
			sum_s3  <= ACC_W'(acc_q + prod_s2 + bias_s2);
		end
	end

	//--------------------------------------------------------------------------
	// result conversion
	//--------------------------------------------------------------------------
	assign post_ctl.err     = err_s3;
	assign post_ctl.use_sig = use_sigmoid_q;

	nws_post u_post (
		.sum    (sum_s3),
		.ctl    (post_ctl),
		.result (post_res)
	);

	//--------------------------------------------------------------------------
	// output register with skid entry
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_vld_q  <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready)
				skid_vld_q <= 1'b0;
		end else if (out_valid_q && !out_ready) begin
			if (res_vld_s3)
				skid_vld_q <= 1'b1;
		end else begin
			out_valid_q <= res_vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_ready) begin
				res_q <= skid_res_q;
				err_q <= skid_err_q;
			end
		end else if (out_valid_q && !out_ready) begin
			skid_res_q <= post_res;
			skid_err_q <= err_s3;
		end else begin
			res_q <= post_res;
			err_q <= err_s3;
		end
	end

	assign out_valid   = out_valid_q;
	assign result      = res_q;
	assign count_error = err_q;

`ifndef SYNTH
	// a count error always carries a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count_error |-> result == '0)
		else $error("count error with nonzero result");

	// sigmoid output stays within 0..1.0
	a_sig_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !count_error && use_sigmoid_q |->
			!result[RES_W-1] && (result[RES_W-2:0] <= (RES_W-1)'(SIG_ONE)))
		else $error("sigmoid result out of range");

	// skid entry only fills behind a held result
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_valid_q)
		else $error("skid entry valid without output valid");

	// the element marked last restarts the count
	a_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc_elem && last |=> cnt_q == '0)
		else $error("element count not cleared after last");
`endif

endmodule

[hw/rtl/nws_post.sv]
// Result stage: Q.24 to Q.12 conversion, PLAN sigmoid and error select.
module nws_post (
	input  logic signed [nws_pkg::ACC_W-1:0] sum,
	input  nws_pkg::nws_post_ctl_t           ctl,
	output logic signed [nws_pkg::RES_W-1:0] result
);
	import nws_pkg::*;

	logic signed [Q_W-1:0] q12;
	logic [Q_W-1:0]        mag;
	logic [SIG_W-1:0]      y_pos;
	logic [SIG_W-1:0]      y_sig;

	// arithmetic shift right by 12 (floor); a 28-bit value never needs 32-bit saturation
	assign q12 = sum[ACC_W-1:FRAC_BITS];
	assign mag = q12[Q_W-1] ? Q_W'(-q12) : Q_W'(q12);

	always_comb begin
		if (mag >= SIG_SAT_TH)
			y_pos = SIG_ONE;
		else if (mag >= SIG_MID_TH)
			y_pos = SIG_W'(mag >> 5) + SIG_OFS_HI;
		else if (mag >= SIG_LOW_TH)
			y_pos = SIG_W'(mag >> 3) + SIG_OFS_MID;
		else
			y_pos = SIG_W'(mag >> 2) + SIG_OFS_LO;
	end

	// odd symmetry around 0.5
	assign y_sig = q12[Q_W-1] ? SIG_W'(SIG_ONE - y_pos) : y_pos;

	always_comb begin
		if (ctl.err)
			result = '0;
		else if (ctl.use_sig)
			result = RES_W'({1'b0, y_sig});
		else
			result = RES_W'(q12);
	end

endmodule
